// ===== rtl/ambient_light_backlight_controller_defines.svh =====
// Assertion macros shared by the controller RTL.
`ifndef AMBIENT_LIGHT_BACKLIGHT_CONTROLLER_DEFINES_SVH
`define AMBIENT_LIGHT_BACKLIGHT_CONTROLLER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ALS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ALS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/als_pkg.sv =====
package als_pkg;

   localparam int LEVEL_W = 10;

   // Configuration register indexes.
   typedef enum logic [2:0] {
      CSR_ALPHA_UP        = 3'd0,
      CSR_ALPHA_DOWN      = 3'd1,
      CSR_CURVE_MIDPOINT  = 3'd2,
      CSR_HYSTERESIS_BAND = 3'd3,
      CSR_RAMP_SHIFT      = 3'd4,
      CSR_MIN_LEVEL       = 3'd5,
      CSR_MAX_LEVEL       = 3'd6
   } als_csr_type;

   localparam logic [7:0]  ALPHA_UP_RST   = 8'd77;
   localparam logic [7:0]  ALPHA_DOWN_RST = 8'd20;
   localparam logic [9:0]  MIDPOINT_RST   = 10'd50;
   localparam logic [5:0]  BAND_RST       = 6'd6;
   localparam logic [2:0]  SHIFT_RST      = 3'd3;
   localparam logic [9:0]  MIN_LEVEL_RST  = 10'd2;
   localparam logic [9:0]  MAX_LEVEL_RST  = 10'd510;
   localparam logic [7:0]  SLIDER_RST     = 8'd128;
   localparam logic [7:0]  SLIDER_FULL    = 8'd255;

   // Control to the sample window: writes and clears from the input, start from the sequencer.
   typedef struct packed {
      logic wr_en;
      logic clear;
      logic start;
   } als_win_ctl_type;

   // A value below lo gives lo, otherwise one above hi gives hi.
   function automatic logic [LEVEL_W-1:0] als_clamp(input logic signed [12:0] v,
                                                    input logic [LEVEL_W-1:0] lo,
                                                    input logic [LEVEL_W-1:0] hi);
      logic [LEVEL_W-1:0] r;
      if (v < $signed({3'b000, lo})) begin
         r = lo;
      end else if (v > $signed({3'b000, hi})) begin
         r = hi;
      end else begin
         r = v[LEVEL_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== rtl/als_req_if.sv =====
interface als_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [15:0] lux_sample;
   logic       auto_mode;
   logic       slider_valid;
   logic [7:0] slider_level;

   modport source (output valid, kind, lux_sample, auto_mode, slider_valid, slider_level,
                   input ready);
   modport sink (input valid, kind, lux_sample, auto_mode, slider_valid, slider_level,
                 output ready);
endinterface

// ===== rtl/als_rsp_if.sv =====
interface als_rsp_if;
   logic        valid;
   logic        ready;
   logic [9:0]  backlight_level;
   logic        level_written;
   logic [9:0]  target_level;
   logic [15:0] filtered_lux;

   modport source (output valid, backlight_level, level_written, target_level, filtered_lux,
                   input ready);
   modport sink (input valid, backlight_level, level_written, target_level, filtered_lux,
                 output ready);
endinterface

// ===== rtl/als_div.sv =====
module als_div #(
   parameter int NUMW = 27,
   parameter int DENW = 18
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [NUMW-1:0] dividend,
   input  logic [DENW-1:0] divisor,
   output logic            busy,
   output logic            done,
   output logic [NUMW-1:0] quotient
);

   localparam int CNTW = $clog2(NUMW + 1);

   logic [NUMW-1:0] dvd_ff;
   logic [DENW-1:0] rem_ff;
   logic [DENW-1:0] dsr_ff;
   logic [CNTW-1:0] cnt_ff;
   logic            busy_ff;
   logic            done_ff;
   logic [DENW:0]   rem_sh;
   logic            fits;

   // One quotient bit per cycle, restoring form.
   assign rem_sh = {rem_ff, dvd_ff[NUMW-1]};
   assign fits   = rem_sh >= {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            dvd_ff  <= dividend;
            dsr_ff  <= divisor;
            rem_ff  <= '0;
            cnt_ff  <= CNTW'(NUMW);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (fits) begin
               rem_ff <= DENW'(rem_sh - {1'b0, dsr_ff});
            end else begin
               rem_ff <= rem_sh[DENW-1:0];
            end
            dvd_ff <= {dvd_ff[NUMW-2:0], fits};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNTW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

// ===== rtl/als_window.sv =====
module als_window import als_pkg::*; #(
   parameter int WINDOW_SIZE = 5,
   parameter int LUX_BITS    = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  als_win_ctl_type     ctl,
   input  logic [LUX_BITS-1:0] wr_data,
   output logic                done,
   output logic [LUX_BITS-1:0] median
);

   localparam int CW = $clog2(WINDOW_SIZE + 1);
   localparam int IW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;

   typedef enum logic [2:0] {M_IDLE, M_LOAD, M_SCAN, M_NEXT, M_DONE} med_state_type;

   med_state_type       state_ff;
   logic [LUX_BITS-1:0] win_ff [WINDOW_SIZE];
   logic [CW-1:0]       count_ff;
   logic [CW-1:0]       index_ff;
   logic [CW-1:0]       i_ff;
   logic [CW-1:0]       j_ff;
   logic [CW-1:0]       rank_ff;
   logic [LUX_BITS-1:0] cand_ff;
   logic [LUX_BITS-1:0] lo_ff;
   logic [LUX_BITS-1:0] hi_ff;
   logic [CW-1:0]       rd_idx;
   logic [LUX_BITS-1:0] rd_val;
   logic [CW-1:0]       last_idx;
   logic [CW-1:0]       k_lo;
   logic [CW-1:0]       k_hi;
   logic                below;
   logic [LUX_BITS:0]   mid_sum;

   // A single read port serves both the candidate load and the scan.
   assign rd_idx   = (state_ff == M_LOAD) ? i_ff : j_ff;
   assign rd_val   = win_ff[rd_idx[IW-1:0]];
   assign last_idx = count_ff - 1'b1;
   assign k_lo     = last_idx >> 1;
   assign k_hi     = count_ff >> 1;
   // Ties rank by position so every entry gets a distinct rank.
   assign below    = (rd_val < cand_ff) || ((rd_val == cand_ff) && (j_ff < i_ff));
   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         win_ff[index_ff[IW-1:0]] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         count_ff <= '0;
         index_ff <= '0;
      end else begin
         if (ctl.clear) begin
            count_ff <= '0;
            index_ff <= '0;
         end else if (ctl.wr_en) begin
            index_ff <= (index_ff == CW'(WINDOW_SIZE - 1)) ? '0 : index_ff + 1'b1;
            if (count_ff != CW'(WINDOW_SIZE)) begin
               count_ff <= count_ff + 1'b1;
            end
         end
         unique case (state_ff)
            M_IDLE: begin
               if (ctl.start) begin
                  i_ff <= '0;
                  if (count_ff == '0) begin
                     lo_ff    <= '0;
                     hi_ff    <= '0;
                     state_ff <= M_DONE;
                  end else begin
                     state_ff <= M_LOAD;
                  end
               end
            end
            M_LOAD: begin
               cand_ff  <= rd_val;
               j_ff     <= '0;
               rank_ff  <= '0;
               state_ff <= M_SCAN;
            end
            M_SCAN: begin
               if (below) begin
                  rank_ff <= rank_ff + 1'b1;
               end
               if (j_ff == last_idx) begin
                  state_ff <= M_NEXT;
               end else begin
                  j_ff <= j_ff + 1'b1;
               end
            end
            M_NEXT: begin
               if (rank_ff == k_lo) begin
                  lo_ff <= cand_ff;
               end
               if (rank_ff == k_hi) begin
                  hi_ff <= cand_ff;
               end
               if (i_ff == last_idx) begin
                  state_ff <= M_DONE;
               end else begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= M_LOAD;
               end
            end
            M_DONE: begin
               state_ff <= M_IDLE;
            end
            default: begin
               state_ff <= M_IDLE;
            end
         endcase
      end
   end

   assign done   = (state_ff == M_DONE);
   assign median = mid_sum[LUX_BITS:1];

endmodule

// ===== rtl/ambient_light_backlight_controller.sv =====
// Ambient-light backlight controller.
// The req_chan channel carries light samples (kind 0) and frame ticks (kind 1);
// a transaction is accepted when valid and ready are both high. A light sample
// is stored and returns nothing. Each tick returns exactly one transaction on
// rsp_chan with the backlight level, whether it was written, the target (ramp
// goal in auto mode, slider map in manual) and the filtered lux (zero in
// manual). Registers are to be written through csr_* only while the block is
// idle; the block does not enforce this. There is no read-back. A tick is
// processed by a small sequencer around one shared restoring divider of
// LUX_BITS+11 bits (one quotient bit per cycle, done flag at the end) and a
// rank based median search over the window. An auto tick runs the median
// search, filter, curve division and ramp, skipping the division at zero
// filtered lux and the filter update on the first tick after a mode change;
// a slider move that captures a new offset adds a slider-map division. A
// manual tick runs the slider-map division, skipped when the slider sits at
// either end. ready is low while a tick is in work and during reset.
// The result sits in an output register; the next item is accepted while
// it waits, but a following tick holds its result until the slot frees.
// Synchronous reset restores the register defaults and clears all history.
`include "ambient_light_backlight_controller_defines.svh"

module ambient_light_backlight_controller import als_pkg::*; #(
   parameter int WINDOW_SIZE = 5,
   parameter int LUX_BITS    = 16
) (
   input  logic       clock,
   input  logic       reset,
   als_req_if.sink    req_chan,
   als_rsp_if.source  rsp_chan,
   input  logic       csr_wr_en,
   input  logic [2:0] csr_index,
   input  logic [9:0] csr_wr_data
);

   localparam int FW   = LUX_BITS + 8;           // filter, 8 fraction bits
   localparam int FX_W = LUX_BITS + 1;           // rounded filter
   localparam int NUMW = FX_W + LEVEL_W;         // divider dividend
   localparam int DENW = FX_W + 1;               // divider divisor
   localparam int EXT_W = (LUX_BITS > 16 ? LUX_BITS : 16) + 1;
   localparam int FXE  = (FX_W > 17) ? FX_W : 17;

   typedef enum logic [3:0] {
      S_IDLE, S_MED_GO, S_MED_WAIT, S_EMA, S_EMA_MUL, S_EMA_UPD, S_FLUX, S_CURVE,
      S_CURVE_WAIT, S_SLIDE, S_SMAP_GO, S_SMAP_WAIT, S_SMAP_DONE, S_TARGET, S_RAMP,
      S_OUT
   } seq_state_type;

   // Configuration registers.
   logic [7:0]  alpha_up_ff, alpha_down_ff;
   logic [9:0]  midpoint_ff;
   logic [5:0]  band_ff;
   logic [2:0]  shift_ff;
   logic [9:0]  min_ff, max_ff;

   seq_state_type       state_ff;
   logic                mode_ff;
   logic                sv_ff;
   logic [7:0]          sw_ff;
   logic [7:0]          manual_ff;
   logic                last_mode_ff, last_mode_valid_ff;
   logic [FW-1:0]       filt_ff;
   logic                filt_valid_ff;
   logic                up_ff;
   logic [FW-1:0]       diff_ff;
   logic [FW+7:0]       prod_ff;
   logic [LUX_BITS-1:0] med_ff;
   logic [FX_W-1:0]     flux_ff;
   logic [9:0]          auto_ff;
   logic signed [10:0]  offset_ff;
   logic [7:0]          last_slider_ff;
   logic                last_slider_valid_ff;
   logic [9:0]          smap_ff;
   logic                neg_ff;
   logic [9:0]          goal_ff;
   logic                goal_valid_ff;
   logic [9:0]          cur_ff;
   logic                cur_valid_ff;
   logic                written_ff;
   logic                rsp_valid_ff;
   logic [9:0]          rsp_level_ff;
   logic                rsp_written_ff;
   logic [9:0]          rsp_target_ff;
   logic [15:0]         rsp_flux_ff;

   logic                req_fire;
   logic                mode_change;
   logic [EXT_W-1:0]    lux_ext;
   logic [EXT_W-1:0]    lux_max_ext;
   logic [LUX_BITS-1:0] lux_sat;
   als_win_ctl_type     win_ctl;
   logic                med_done;
   logic [LUX_BITS-1:0] med_val;
   logic                div_start;
   logic [NUMW-1:0]     div_dvd;
   logic [DENW-1:0]     div_dsr;
   logic                div_busy;
   logic                div_done;
   logic [NUMW-1:0]     div_quot;
   logic [FW-1:0]       med_q;
   logic [7:0]          alpha_sel;
   logic [FW+7:0]       ema_prod;
   logic [FW-1:0]       ema_step;
   logic [FW:0]         filt_round;
   logic [NUMW-1:0]     curve_num;
   logic [DENW-1:0]     curve_den;
   logic signed [10:0]  lvl_span;
   logic [9:0]          span_abs;
   logic [17:0]         slider_prod;
   logic [9:0]          smap_q;
   logic [10:0]         smap_calc;
   logic signed [10:0]  off_calc;
   logic signed [12:0]  tgt_sum;
   logic [9:0]          tgt;
   logic [9:0]          tgt_dist;
   logic [9:0]          ramp_dist;
   logic [9:0]          ramp_raw;
   logic [9:0]          ramp_step;
   logic [FXE-1:0]      flux_ext;
   logic [15:0]         flux_out;
   logic                offset_capture;

   // Input handling: ready only between ticks and never during reset.
   assign req_chan.ready = (state_ff == S_IDLE) && !reset;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign mode_change    = !last_mode_valid_ff || (req_chan.auto_mode != last_mode_ff);

   // Samples above the lux range saturate.
   assign lux_ext     = EXT_W'(req_chan.lux_sample);
   assign lux_max_ext = EXT_W'((64'd1 << LUX_BITS) - 64'd1);
   assign lux_sat     = (lux_ext > lux_max_ext) ? lux_max_ext[LUX_BITS-1:0]
                                                : lux_ext[LUX_BITS-1:0];

   assign win_ctl.wr_en = req_fire && !req_chan.kind;
   assign win_ctl.clear = req_fire && req_chan.kind && mode_change;
   assign win_ctl.start = (state_ff == S_MED_GO);

   als_window #(.WINDOW_SIZE(WINDOW_SIZE), .LUX_BITS(LUX_BITS)) u_window (
      .clock   (clock),
      .reset   (reset),
      .ctl     (win_ctl),
      .wr_data (lux_sat),
      .done    (med_done),
      .median  (med_val)
   );

   // Filter arithmetic: one multiplier, registered before the update.
   assign med_q      = {med_ff, 8'h00};
   assign alpha_sel  = up_ff ? alpha_up_ff : alpha_down_ff;
   assign ema_prod   = diff_ff * alpha_sel;
   assign ema_step   = prod_ff[FW+7:8];
   assign filt_round = {1'b0, filt_ff} + (FW+1)'(128);

   // Curve operands: level = lux * max_level / (lux + curve_midpoint).
   assign curve_num = flux_ff * max_ff;
   assign curve_den = {1'b0, flux_ff} + DENW'(midpoint_ff);

   // Slider map: min + slider * (max - min) / 255, truncated toward zero.
   assign lvl_span    = $signed({1'b0, max_ff}) - $signed({1'b0, min_ff});
   assign span_abs    = lvl_span[10] ? 10'(-lvl_span) : lvl_span[9:0];
   assign slider_prod = sw_ff * span_abs;
   assign smap_q      = div_quot[9:0];
   assign smap_calc   = neg_ff ? ({1'b0, min_ff} - {1'b0, smap_q})
                               : ({1'b0, min_ff} + {1'b0, smap_q});

   // The shared divider serves the curve and the slider map.
   always_comb begin
      div_start = 1'b0;
      div_dvd   = NUMW'(slider_prod);
      div_dsr   = DENW'(SLIDER_FULL);
      if (state_ff == S_CURVE) begin
         div_start = (flux_ff != '0);
         div_dvd   = curve_num;
         div_dsr   = curve_den;
      end else if (state_ff == S_SMAP_GO) begin
         div_start = (sw_ff != SLIDER_FULL) && (sw_ff != 8'h00);
      end
   end

   als_div #(.NUMW(NUMW), .DENW(DENW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dsr),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Offset, target and hysteresis.
   assign off_calc  = $signed({1'b0, smap_ff}) - $signed({1'b0, auto_ff});
   assign tgt_sum   = $signed({3'b000, auto_ff}) + {{2{offset_ff[10]}}, offset_ff};
   assign tgt       = als_clamp(tgt_sum, min_ff, max_ff);
   assign tgt_dist  = (tgt > goal_ff) ? (tgt - goal_ff) : (goal_ff - tgt);

   // Proportional ramp, never less than one step.
   assign ramp_dist = (goal_ff > cur_ff) ? (goal_ff - cur_ff) : (cur_ff - goal_ff);
   assign ramp_raw  = ramp_dist >> shift_ff;
   assign ramp_step = (ramp_raw == '0) ? 10'd1 : ramp_raw;

   assign offset_capture = sv_ff && last_slider_valid_ff && (sw_ff != last_slider_ff);

   assign flux_ext = FXE'(flux_ff);
   assign flux_out = (flux_ext > FXE'(16'hFFFF)) ? 16'hFFFF : flux_ext[15:0];

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_up_ff   <= ALPHA_UP_RST;
         alpha_down_ff <= ALPHA_DOWN_RST;
         midpoint_ff   <= MIDPOINT_RST;
         band_ff       <= BAND_RST;
         shift_ff      <= SHIFT_RST;
         min_ff        <= MIN_LEVEL_RST;
         max_ff        <= MAX_LEVEL_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ALPHA_UP:        alpha_up_ff   <= csr_wr_data[7:0];
            CSR_ALPHA_DOWN:      alpha_down_ff <= csr_wr_data[7:0];
            CSR_CURVE_MIDPOINT:  midpoint_ff   <= csr_wr_data;
            CSR_HYSTERESIS_BAND: band_ff       <= csr_wr_data[5:0];
            CSR_RAMP_SHIFT:      shift_ff      <= csr_wr_data[2:0];
            CSR_MIN_LEVEL:       min_ff        <= csr_wr_data;
            CSR_MAX_LEVEL:       max_ff        <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   // Tick sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff             <= S_IDLE;
         manual_ff            <= SLIDER_RST;
         last_mode_valid_ff   <= 1'b0;
         filt_valid_ff        <= 1'b0;
         filt_ff              <= '0;
         offset_ff            <= '0;
         last_slider_valid_ff <= 1'b0;
         goal_valid_ff        <= 1'b0;
         cur_valid_ff         <= 1'b0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         // In S_OUT the output register is reloaded instead of emptied.
         if (rsp_valid_ff && rsp_chan.ready && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire && req_chan.kind) begin
                  written_ff <= 1'b0;
                  mode_ff    <= req_chan.auto_mode;
                  sv_ff      <= req_chan.slider_valid;
                  if (req_chan.auto_mode || req_chan.slider_valid) begin
                     sw_ff <= req_chan.slider_level;
                  end else begin
                     sw_ff <= manual_ff;
                  end
                  if (!req_chan.auto_mode && req_chan.slider_valid) begin
                     manual_ff <= req_chan.slider_level;
                  end
                  // A change of mode restarts the filter chain.
                  if (mode_change) begin
                     last_mode_ff         <= req_chan.auto_mode;
                     last_mode_valid_ff   <= 1'b1;
                     filt_valid_ff        <= 1'b0;
                     filt_ff              <= '0;
                     goal_valid_ff        <= 1'b0;
                     offset_ff            <= '0;
                     last_slider_valid_ff <= 1'b0;
                  end
                  state_ff <= req_chan.auto_mode ? S_MED_GO : S_SMAP_GO;
               end
            end
            S_MED_GO: begin
               state_ff <= S_MED_WAIT;
            end
            S_MED_WAIT: begin
               if (med_done) begin
                  med_ff   <= med_val;
                  state_ff <= S_EMA;
               end
            end
            S_EMA: begin
               if (!filt_valid_ff) begin
                  filt_ff       <= med_q;
                  filt_valid_ff <= 1'b1;
                  state_ff      <= S_FLUX;
               end else begin
                  up_ff    <= (med_q > filt_ff);
                  diff_ff  <= (med_q > filt_ff) ? (med_q - filt_ff) : (filt_ff - med_q);
                  state_ff <= S_EMA_MUL;
               end
            end
            S_EMA_MUL: begin
               prod_ff  <= ema_prod;
               state_ff <= S_EMA_UPD;
            end
            S_EMA_UPD: begin
               filt_ff  <= up_ff ? (filt_ff + ema_step) : (filt_ff - ema_step);
               state_ff <= S_FLUX;
            end
            S_FLUX: begin
               flux_ff  <= filt_round[FW:8];
               state_ff <= S_CURVE;
            end
            S_CURVE: begin
               // Zero lux maps straight to the lowest level.
               if (flux_ff == '0) begin
                  auto_ff  <= min_ff;
                  state_ff <= S_SLIDE;
               end else begin
                  state_ff <= S_CURVE_WAIT;
               end
            end
            S_CURVE_WAIT: begin
               if (div_done) begin
                  auto_ff  <= als_clamp({3'b000, div_quot[9:0]}, min_ff, max_ff);
                  state_ff <= S_SLIDE;
               end
            end
            S_SLIDE: begin
               if (sv_ff) begin
                  last_slider_ff       <= sw_ff;
                  last_slider_valid_ff <= 1'b1;
               end
               state_ff <= offset_capture ? S_SMAP_GO : S_TARGET;
            end
            S_SMAP_GO: begin
               neg_ff <= lvl_span[10];
               if (sw_ff == SLIDER_FULL) begin
                  smap_ff  <= max_ff;
                  state_ff <= S_SMAP_DONE;
               end else if (sw_ff == 8'h00) begin
                  smap_ff  <= min_ff;
                  state_ff <= S_SMAP_DONE;
               end else begin
                  state_ff <= S_SMAP_WAIT;
               end
            end
            S_SMAP_WAIT: begin
               if (div_done) begin
                  smap_ff  <= smap_calc[9:0];
                  state_ff <= S_SMAP_DONE;
               end
            end
            S_SMAP_DONE: begin
               if (mode_ff) begin
                  offset_ff <= off_calc;
                  state_ff  <= S_TARGET;
               end else begin
                  written_ff   <= !cur_valid_ff || (cur_ff != smap_ff);
                  cur_ff       <= smap_ff;
                  cur_valid_ff <= 1'b1;
                  state_ff     <= S_OUT;
               end
            end
            S_TARGET: begin
               if (!goal_valid_ff || (tgt_dist > {4'b0000, band_ff})) begin
                  goal_ff <= tgt;
               end
               goal_valid_ff <= 1'b1;
               state_ff      <= S_RAMP;
            end
            S_RAMP: begin
               if (!cur_valid_ff) begin
                  cur_ff       <= goal_ff;
                  cur_valid_ff <= 1'b1;
                  written_ff   <= 1'b1;
               end else if (cur_ff != goal_ff) begin
                  cur_ff     <= (goal_ff > cur_ff) ? (cur_ff + ramp_step)
                                                   : (cur_ff - ramp_step);
                  written_ff <= 1'b1;
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               // Wait for the output register to free before reporting.
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_level_ff   <= cur_ff;
                  rsp_written_ff <= written_ff;
                  rsp_target_ff  <= mode_ff ? goal_ff : smap_ff;
                  rsp_flux_ff    <= mode_ff ? flux_out : 16'h0000;
                  state_ff       <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.backlight_level = rsp_level_ff;
   assign rsp_chan.level_written   = rsp_written_ff;
   assign rsp_chan.target_level    = rsp_target_ff;
   assign rsp_chan.filtered_lux    = rsp_flux_ff;

   // The divider only runs inside a tick, never while new items are taken.
   `ALS_ASSERT_NOW(a_div_idle_when_ready, req_chan.ready, !div_busy, "divider busy while ready")
   // An accepted tick closes the input until its result is formed.
   `ALS_ASSERT_NEXT(a_tick_blocks_input, req_fire && req_chan.kind, !req_chan.ready,
                    "input still open after a tick")
   // An auto result always carries a valid goal and current level.
   `ALS_ASSERT_NOW(a_auto_state_valid, (state_ff == S_OUT) && mode_ff,
                   goal_valid_ff && cur_valid_ff, "auto result without ramp state")

endmodule

// ===== tb/sv/tb_ambient_light_backlight_controller.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the ambient-light backlight controller.
// A behavioral model of the tick pipeline (window median, asymmetric EMA,
// saturating curve, slider offset, hysteresis and ramp) runs alongside the
// block. Every accepted tick pushes one expectation, and every response
// transaction is compared field by field against the oldest one.
module tb_ambient_light_backlight_controller import als_pkg::*; ();

   localparam int WIN_DEPTH   = 5;
   localparam int SETTLE_CYC  = 150;   // longer than the slowest tick with a slider capture
   localparam int WDOG_LIMIT  = 5000;  // idle cycles before the run is declared hung
   localparam int LONG_HOLD   = 400;   // forced response back-pressure, in cycles
   localparam int RAND_ITEMS  = 1000;
   localparam int NUM_PHASES  = 8;

   typedef struct {
      logic [9:0]  level;
      logic        written;
      logic [9:0]  target;
      logic [15:0] flux;
   } bl_result_type;

   // One directed row. When chk is set, the typed result is what we expect;
   // otherwise the model supplies it.
   typedef struct {
      logic        kind;
      logic [15:0] lux;
      logic        auto_mode;
      logic        slider_valid;
      logic [7:0]  slider_level;
      logic        chk;
      logic [9:0]  level;
      logic        written;
      logic [9:0]  target;
      logic [15:0] flux;
   } dir_row_type;

   logic clock;
   logic reset;
   logic       csr_wr_en;
   als_csr_type csr_index;
   logic [9:0] csr_wr_data;

   als_req_if req_if ();
   als_rsp_if rsp_if ();

   ambient_light_backlight_controller u_top (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // ---------------------------------------------------------------------
   // Model state. The registers mirror what was written over the CSR port.
   // ---------------------------------------------------------------------
   int unsigned m_alpha_up, m_alpha_down, m_midpoint, m_band, m_shift;
   int          m_min_lvl, m_max_lvl;

   logic [15:0] lux_win [WIN_DEPTH];
   int unsigned win_cnt, win_idx;
   logic [31:0] ema_q8;
   bit          ema_valid;
   int          slider_bias;
   int unsigned prev_slider;
   bit          prev_slider_valid;
   int          ramp_goal;
   bit          goal_valid;
   int          cur_level;
   bit          cur_valid;
   int unsigned manual_slider;
   bit          prev_mode;
   bit          prev_mode_valid;

   bl_result_type pending_results[$];

   int errors;
   int ticks_sent, samples_sent, results_checked, csr_writes;
   bit hold_request;

   // Register defaults and cleared history, as after reset.
   task automatic model_reset();
      m_alpha_up = ALPHA_UP_RST;  m_alpha_down = ALPHA_DOWN_RST;
      m_midpoint = MIDPOINT_RST;  m_band = BAND_RST;  m_shift = SHIFT_RST;
      m_min_lvl = MIN_LEVEL_RST;  m_max_lvl = MAX_LEVEL_RST;
      foreach (lux_win[i]) lux_win[i] = '0;
      win_cnt = 0; win_idx = 0;
      ema_q8 = '0; ema_valid = 0;
      slider_bias = 0;
      prev_slider = 0; prev_slider_valid = 0;
      ramp_goal = 0; goal_valid = 0;
      cur_level = 0; cur_valid = 0;
      manual_slider = SLIDER_RST;
      prev_mode = 0; prev_mode_valid = 0;
   endtask

   // A value below min gives min, else one above max gives max; min wins if both apply.
   function automatic int clamp_lvl(int v);
      if (v < m_min_lvl) return m_min_lvl;
      if (v > m_max_lvl) return m_max_lvl;
      return v;
   endfunction

   function automatic int unsigned window_median();
      int unsigned s [WIN_DEPTH];
      int unsigned n, v;
      int j;
      n = win_cnt;
      if (n == 0) return 0;
      for (int i = 0; i < n; i++) s[i] = lux_win[i];
      for (int i = 1; i < n; i++) begin
         v = s[i];
         j = i;
         while (j > 0 && s[j-1] > v) begin
            s[j] = s[j-1];
            j--;
         end
         s[j] = v;
      end
      if (n % 2 == 1) return s[n/2];
      return (s[n/2-1] + s[n/2]) / 2;
   endfunction

   function automatic int lux_to_level(int unsigned lux);
      longint unsigned num, den;
      if (lux == 0) return m_min_lvl;
      num = longint'(lux) * m_max_lvl;
      den = longint'(lux) + m_midpoint;
      return clamp_lvl(int'(num / den));
   endfunction

   function automatic int slider_to_level(int unsigned sw);
      if (sw >= SLIDER_FULL) return m_max_lvl;
      if (sw == 0) return m_min_lvl;
      return m_min_lvl + (int'(sw) * (m_max_lvl - m_min_lvl)) / 255;
   endfunction

   // Advances the model by one accepted transaction. Returns 1 for a tick,
   // with the backlight result it must produce.
   function automatic bit backlight_step(input logic kind, input logic [15:0] lux,
                                         input logic auto_mode, input logic slider_valid,
                                         input logic [7:0] slider_level,
                                         output bl_result_type res);
      logic [31:0] med_q8;
      int unsigned flux;
      int auto_lvl, tgt, delta, step;
      bit written;
      written = 0;
      flux = 0;
      res = '{default: '0};
      if (kind == 1'b0) begin
         lux_win[win_idx] = lux;
         win_idx = (win_idx + 1) % WIN_DEPTH;
         if (win_cnt < WIN_DEPTH) win_cnt++;
         return 0;
      end

      // A mode change clears history but keeps the level on the panel.
      if (!prev_mode_valid || auto_mode != prev_mode) begin
         prev_mode = auto_mode; prev_mode_valid = 1;
         ema_valid = 0; ema_q8 = '0;
         goal_valid = 0;
         win_cnt = 0; win_idx = 0;
         slider_bias = 0;
         prev_slider_valid = 0;
      end

      if (auto_mode) begin
         med_q8 = window_median() << 8;
         if (!ema_valid) begin
            ema_q8 = med_q8;
            ema_valid = 1;
         end else if (med_q8 > ema_q8) begin
            ema_q8 += 32'((64'(med_q8 - ema_q8) * m_alpha_up) >> 8);
         end else begin
            ema_q8 -= 32'((64'(ema_q8 - med_q8) * m_alpha_down) >> 8);
         end
         flux = (ema_q8 + 128) >> 8;
         auto_lvl = lux_to_level(flux);

         if (slider_valid) begin
            if (prev_slider_valid && slider_level != prev_slider)
               slider_bias = slider_to_level(slider_level) - auto_lvl;
            prev_slider = slider_level;
            prev_slider_valid = 1;
         end

         tgt = clamp_lvl(auto_lvl + slider_bias);
         if (!goal_valid) begin
            ramp_goal = tgt;
            goal_valid = 1;
         end else begin
            delta = (tgt > ramp_goal) ? tgt - ramp_goal : ramp_goal - tgt;
            if (delta > int'(m_band)) ramp_goal = tgt;
         end

         if (!cur_valid) begin
            cur_level = ramp_goal;
            cur_valid = 1;
            written = 1;
         end
         if (cur_level != ramp_goal) begin
            delta = (ramp_goal > cur_level) ? ramp_goal - cur_level : cur_level - ramp_goal;
            step = delta >> m_shift;
            if (step < 1) step = 1;
            if (ramp_goal > cur_level) begin
               cur_level += step;
               if (cur_level > ramp_goal) cur_level = ramp_goal;
            end else begin
               cur_level -= step;
               if (cur_level < ramp_goal) cur_level = ramp_goal;
            end
            written = 1;
         end
         tgt = ramp_goal;
         if (flux > 16'hFFFF) flux = 16'hFFFF;
      end else begin
         if (slider_valid) manual_slider = slider_level;
         tgt = slider_to_level(manual_slider);
         if (!cur_valid || cur_level != tgt) written = 1;
         cur_level = tgt;
         cur_valid = 1;
         flux = 0;
      end

      res.level   = cur_level[9:0];
      res.written = written;
      res.target  = tgt[9:0];
      res.flux    = flux[15:0];
      return 1;
   endfunction

   // ---------------------------------------------------------------------
   // Clock, reset and idle values.
   // ---------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------------
   // Response side: random back-pressure, with stretches of none, plus one
   // long forced hold requested by the stimulus so the block fills up.
   // ---------------------------------------------------------------------
   int hold_left;
   int mode_left;
   bit ready_always;

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         hold_left    <= 0;
         mode_left    <= 0;
         ready_always <= 1'b0;
      end else if (hold_request) begin
         // The stimulus asked for a long hold; count it here.
         hold_request <= 1'b0;
         hold_left    <= LONG_HOLD;
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left    <= hold_left - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            mode_left    <= $urandom_range(300, 50);
            ready_always <= ($urandom_range(2, 0) == 0);
         end else begin
            mode_left <= mode_left - 1;
         end
         if (ready_always) begin
            rsp_if.ready <= 1'b1;
         end else if ($urandom_range(99, 0) < 3) begin
            hold_left    <= $urandom_range(60, 15);
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(3, 0) != 0);
         end
      end
   end

   // Every response transaction is checked against the oldest expectation.
   always @(posedge clock) begin
      bl_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response level=%0d written=%0b target=%0d lux=%0d",
                     $time, rsp_if.backlight_level, rsp_if.level_written,
                     rsp_if.target_level, rsp_if.filtered_lux);
            errors++;
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (rsp_if.backlight_level !== want.level) begin
               $display("%0t: backlight_level expected %0d actual %0d",
                        $time, want.level, rsp_if.backlight_level);
               errors++;
            end
            if (rsp_if.level_written !== want.written) begin
               $display("%0t: level_written expected %0b actual %0b",
                        $time, want.written, rsp_if.level_written);
               errors++;
            end
            if (rsp_if.target_level !== want.target) begin
               $display("%0t: target_level expected %0d actual %0d",
                        $time, want.target, rsp_if.target_level);
               errors++;
            end
            if (rsp_if.filtered_lux !== want.flux) begin
               $display("%0t: filtered_lux expected %0d actual %0d",
                        $time, want.flux, rsp_if.filtered_lux);
               errors++;
            end
         end
      end
   end

   // The watchdog counts cycles in which no transaction moves on either side.
   int idle_cycles;
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WDOG_LIMIT) begin
         $display("%0t: timeout, %0d results still outstanding", $time,
                  pending_results.size());
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Request side.
   // ---------------------------------------------------------------------
   bit sender_gaps;  // when clear, items go back to back

   // Offers one item and waits until it is accepted. The valid is only
   // lowered when a gap follows, so back-to-back items never see it bounce.
   task automatic send_item(input logic kind, input logic [15:0] lux,
                            input logic auto_mode, input logic slider_valid,
                            input logic [7:0] slider_level,
                            input bit use_typed, input bl_result_type typed);
      bl_result_type predicted;
      int gap;
      req_if.valid        <= 1'b1;
      req_if.kind         <= kind;
      req_if.lux_sample   <= lux;
      req_if.auto_mode    <= auto_mode;
      req_if.slider_valid <= slider_valid;
      req_if.slider_level <= slider_level;
      do @(posedge clock); while (!req_if.ready);
      if (backlight_step(kind, lux, auto_mode, slider_valid, slider_level, predicted)) begin
         pending_results.push_back(use_typed ? typed : predicted);
         ticks_sent++;
      end else begin
         samples_sent++;
      end
      gap = 0;
      if (sender_gaps) begin
         if ($urandom_range(19, 0) == 0) gap = $urandom_range(80, 20);
         else if ($urandom_range(1, 0) == 0) gap = $urandom_range(3, 1);
      end
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic stop_offering();
      req_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Registers are only written with nothing in flight: all results back,
   // then enough cycles for any sample still being stored to settle.
   task automatic wait_idle();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic csr_write(input als_csr_type idx, input logic [9:0] value);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_ALPHA_UP:        m_alpha_up   = value[7:0];
         CSR_ALPHA_DOWN:      m_alpha_down = value[7:0];
         CSR_CURVE_MIDPOINT:  m_midpoint   = value;
         CSR_HYSTERESIS_BAND: m_band       = value[5:0];
         CSR_RAMP_SHIFT:      m_shift      = value[2:0];
         CSR_MIN_LEVEL:       m_min_lvl    = value;
         CSR_MAX_LEVEL:       m_max_lvl    = value;
         default: ;
      endcase
      csr_writes++;
      @(posedge clock);
   endtask

   // Phase 1 opens everything wide, phase 2 closes it down, phase 3 sets other
   // fixed values, both with min above max; later phases pick random ones.
   task automatic program_phase(input int phase);
      logic [9:0] v [7];
      case (phase)
         1: v = '{10'd255, 10'd0, 10'd1, 10'd0, 10'd0, 10'd0, 10'd1023};
         2: v = '{10'd0, 10'd255, 10'd1023, 10'd63, 10'd7, 10'd1023, 10'd1};
         3: v = '{10'd1, 10'd254, 10'd512, 10'd32, 10'd4, 10'd600, 10'd100};
         default: begin
            v[0] = $urandom_range(255, 0);
            v[1] = $urandom_range(255, 0);
            v[2] = $urandom_range(1023, 1);
            v[3] = $urandom_range(63, 0);
            v[4] = $urandom_range(7, 0);
            v[5] = $urandom_range(200, 0);
            v[6] = $urandom_range(1023, 200);
         end
      endcase
      csr_write(CSR_ALPHA_UP,        v[0]);
      csr_write(CSR_ALPHA_DOWN,      v[1]);
      csr_write(CSR_CURVE_MIDPOINT,  v[2]);
      csr_write(CSR_HYSTERESIS_BAND, v[3]);
      csr_write(CSR_RAMP_SHIFT,      v[4]);
      csr_write(CSR_MIN_LEVEL,       v[5]);
      csr_write(CSR_MAX_LEVEL,       v[6]);
   endtask

   function automatic logic [15:0] pick_lux();
      case ($urandom_range(7, 0))
         0:       return 16'd0;
         1:       return 16'hFFFF;
         2, 3:    return 16'($urandom_range(200, 0));
         4:       return 16'($urandom_range(2000, 0));
         default: return 16'($urandom_range(65535, 0));
      endcase
   endfunction

   function automatic logic [7:0] pick_slider();
      case ($urandom_range(7, 0))
         0:       return 8'd0;
         1:       return SLIDER_FULL;
         default: return 8'($urandom_range(255, 0));
      endcase
   endfunction

   // Directed rows with defaults after reset. The first ticks run in manual
   // mode, where the level is a straight slider map and can be typed in.
   dir_row_type dir_rows [] = '{
      // first tick, manual, slider at its reset value of 128: 2+128*508/255
      '{1'b1, 16'd0,     1'b0, 1'b0, 8'd0,   1'b1, 10'd256, 1'b1, 10'd256, 16'd0},
      // slider full scale gives max_level
      '{1'b1, 16'hFFFF,  1'b0, 1'b1, 8'd255, 1'b1, 10'd510, 1'b1, 10'd510, 16'd0},
      // slider at zero gives min_level
      '{1'b1, 16'd0,     1'b0, 1'b1, 8'd0,   1'b1, 10'd2,   1'b1, 10'd2,   16'd0},
      // same level again is not written
      '{1'b1, 16'd0,     1'b0, 1'b1, 8'd0,   1'b1, 10'd2,   1'b0, 10'd2,   16'd0},
      // switch to auto on an empty window: zero lux maps to min_level
      '{1'b1, 16'd0,     1'b1, 1'b0, 8'd0,   1'b1, 10'd2,   1'b0, 10'd2,   16'd0},
      '{1'b0, 16'hFFFF,  1'b1, 1'b1, 8'd255, 1'b0, 10'd0,   1'b0, 10'd0,   16'd0},
      '{1'b0, 16'hFFFF,  1'b0, 1'b0, 8'd0,   1'b0, 10'd0,   1'b0, 10'd0,   16'd0},
      // even count: mean of the middle pair
      '{1'b1, 16'd0,     1'b1, 1'b0, 8'd0,   1'b0, 10'd0,   1'b0, 10'd0,   16'd0},
      '{1'b0, 16'd0,     1'b0, 1'b0, 8'd0,   1'b0, 10'd0,   1'b0, 10'd0,   16'd0},
      '{1'b0, 16'd1,     1'b0, 1'b0, 8'd0,   1'b0, 10'd0,   1'b0, 10'd0,   16'd0},
      '{1'b0, 16'hFFFF,  1'b0, 1'b0, 8'd0,   1'b0, 10'd0,   1'b0, 10'd0,   16'd0},
      // window wraps
      '{1'b0, 16'd300,   1'b0, 1'b0, 8'd0,   1'b0, 10'd0,   1'b0, 10'd0,   16'd0},
      // first slider reading only records history
      '{1'b1, 16'd0,     1'b1, 1'b1, 8'd10,  1'b0, 10'd0,   1'b0, 10'd0,   16'd0},
      // slider moves: the offset is captured
      '{1'b1, 16'd0,     1'b1, 1'b1, 8'd200, 1'b0, 10'd0,   1'b0, 10'd0,   16'd0},
      '{1'b1, 16'd0,     1'b1, 1'b1, 8'd200, 1'b0, 10'd0,   1'b0, 10'd0,   16'd0},
      '{1'b1, 16'd0,     1'b1, 1'b1, 8'd255, 1'b0, 10'd0,   1'b0, 10'd0,   16'd0},
      '{1'b1, 16'd0,     1'b1, 1'b1, 8'd0,   1'b0, 10'd0,   1'b0, 10'd0,   16'd0},
      // back to manual and to auto again: history is cleared both times
      '{1'b1, 16'd0,     1'b0, 1'b1, 8'd77,  1'b0, 10'd0,   1'b0, 10'd0,   16'd0},
      '{1'b1, 16'd0,     1'b1, 1'b0, 8'd0,   1'b0, 10'd0,   1'b0, 10'd0,   16'd0},
      '{1'b0, 16'd0,     1'b0, 1'b0, 8'd0,   1'b0, 10'd0,   1'b0, 10'd0,   16'd0},
      // a single zero sample leaves the filter at zero
      '{1'b1, 16'd0,     1'b1, 1'b0, 8'd0,   1'b0, 10'd0,   1'b0, 10'd0,   16'd0},
      '{1'b1, 16'd0,     1'b1, 1'b0, 8'd0,   1'b0, 10'd0,   1'b0, 10'd0,   16'd0}
   };

   initial begin
      bl_result_type typed;
      int sent, burst;
      bit tick_mode;
      errors = 0; ticks_sent = 0; samples_sent = 0; results_checked = 0; csr_writes = 0;
      hold_request = 1'b0;
      sender_gaps  = 1'b1;
      csr_wr_en    <= 1'b0;
      csr_index    <= CSR_ALPHA_UP;
      csr_wr_data  <= '0;
      req_if.valid        <= 1'b0;
      req_if.kind         <= 1'b0;
      req_if.lux_sample   <= '0;
      req_if.auto_mode    <= 1'b0;
      req_if.slider_valid <= 1'b0;
      req_if.slider_level <= '0;
      model_reset();
      @(posedge clock);
      while (reset) @(posedge clock);

      // Directed part, with the registers at their reset values.
      foreach (dir_rows[i]) begin
         typed = '{dir_rows[i].level, dir_rows[i].written, dir_rows[i].target,
                   dir_rows[i].flux};
         send_item(dir_rows[i].kind, dir_rows[i].lux, dir_rows[i].auto_mode,
                   dir_rows[i].slider_valid, dir_rows[i].slider_level,
                   dir_rows[i].chk, typed);
      end
      stop_offering();

      // Random part, in phases with new register settings. Each phase is
      // mostly bursts of light samples followed by a tick, whose mode flips
      // now and then to exercise mode changes.
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         wait_idle();
         program_phase(phase + 1);
         sender_gaps = (phase % 3 != 2);
         // In one phase the response side stalls for a long time while
         // items keep coming back to back, so the block must stall its input.
         if (phase == 1) begin
            sender_gaps  = 1'b0;
            hold_request = 1'b1;
         end
         tick_mode = 1'b1;
         sent = 0;
         while (sent < RAND_ITEMS / NUM_PHASES) begin
            burst = ($urandom_range(9, 0) == 0) ? 0 : $urandom_range(6, 1);
            repeat (burst) begin
               send_item(1'b0, pick_lux(), 1'($urandom), 1'($urandom), 8'($urandom),
                         1'b0, typed);
               sent++;
            end
            if ($urandom_range(9, 0) == 0) tick_mode = ~tick_mode;
            send_item(1'b1, 16'($urandom), tick_mode, 1'($urandom_range(1, 0)),
                      pick_slider(), 1'b0, typed);
            sent++;
         end
         stop_offering();
      end

      // Drain, then give the block time to show any stray response.
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);

      $display("Covered %0d frame ticks and %0d light samples over %0d register writes,",
               ticks_sent, samples_sent, csr_writes);
      $display("with %0d backlight results compared and %0d mismatches.",
               results_checked, errors);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
